FILE: hw/rtl/lfra_pkg.sv
// Shared types and constants for the lowest-free room allocator.
// Used by lfra_cell and lowest_free_room_allocator_unit; no dependencies.
package lfra_pkg;

	// Number of rooms held by the cell row
	localparam int MAX_ROOMS = 64;
	// Bits of a room index inside the design
	localparam int ROOM_W    = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1;
	// Bits of a room total (0 to MAX_ROOMS)
	localparam int NUM_W     = $clog2(MAX_ROOMS + 1);

	localparam int TIME_W    = 32;
	localparam int CNT_W     = 16;
	localparam int IN_W      = 16;
	localparam int CFG_W     = 7;
	localparam int OUT_ROOM_W = 6;

	// Per-room state held in one cell
	typedef struct packed {
		logic [TIME_W-1:0] free_time;
		logic [CNT_W-1:0]  use_count;
	} room_rec_t;

	// Per-cell control from the sequencer
	typedef struct packed {
		logic shift;
		logic write;
	} cell_ctl_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} seq_state_t;

endpackage

FILE: hw/rtl/lowest_free_room_allocator_unit.sv
// Top level of the lowest-free room allocator: sequencer plus rotating row of room cells.
// Depends on lfra_pkg and lfra_cell.
//
// Usage:
//  - Bookings enter on start_time/end_time; a booking transfers at a clock edge
//    with start high and busy low. Bookings must come in rising start order.
//  - room_count is written through cfg_valid/cfg_ready (ready always high);
//    write it only while the block is idle. Zero acts as one room, values above
//    the row size act as the full row.
//  - For each booking, after its transfer the ring of room cells rotates once past
//    the sequencer (one room inspected per cycle, the rotation length is the row
//    size), then the chosen room is written back and the result registered. busy
//    drops in the cycle the result appears, so a new booking can follow then; no new
//    booking is taken while one is in progress.
//  - The result shows for one cycle with result_valid high; the receiver cannot
//    stall and must take it in that cycle.
//  - Reset clears every room to free time zero and count zero, busiest room to
//    room 0 with count 0, and room_count to 64.
module lowest_free_room_allocator_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [lfra_pkg::IN_W-1:0]            start_time,
	input  logic [lfra_pkg::IN_W-1:0]            end_time,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [lfra_pkg::CFG_W-1:0]           room_count,
	output logic                                 result_valid,
	output logic [lfra_pkg::OUT_ROOM_W-1:0]      assigned_room,
	output logic                                 was_delayed,
	output logic [lfra_pkg::TIME_W-1:0]          finish_time,
	output logic [lfra_pkg::OUT_ROOM_W-1:0]      busiest_room,
	output logic [lfra_pkg::CNT_W-1:0]           busiest_count
);
	import lfra_pkg::*;

	seq_state_t          state_q;
	logic [CFG_W-1:0]    room_count_q;
	logic [IN_W-1:0]     start_q;
	logic [IN_W-1:0]     len_q;
	logic [ROOM_W-1:0]   idx_q;
	logic                found_q;
	logic [ROOM_W-1:0]   found_room_q;
	logic [CNT_W-1:0]    found_cnt_q;
	logic [TIME_W-1:0]   min_free_q;
	logic [ROOM_W-1:0]   min_room_q;
	logic [CNT_W-1:0]    min_cnt_q;
	logic [ROOM_W-1:0]   best_room_q;
	logic [CNT_W-1:0]    best_cnt_q;
	logic                res_valid_q;
	logic [OUT_ROOM_W-1:0] res_room_q;
	logic                res_delayed_q;
	logic [TIME_W-1:0]   res_finish_q;

	room_rec_t           rec [MAX_ROOMS];
	room_rec_t           wr_rec;
	logic                accept;
	logic [NUM_W-1:0]    rooms_used;
	logic                in_range;
	room_rec_t           head;
	logic [ROOM_W-1:0]   sel_room;
	logic [CNT_W-1:0]    sel_cnt;
	logic [CNT_W-1:0]    new_cnt;
	logic [TIME_W-1:0]   base_time;
	logic [TIME_W:0]     sum_time;
	logic [TIME_W-1:0]   fin_time;
	logic                take_best;

	assign accept    = start && (state_q == ST_IDLE);
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign head      = rec[0];

	// Hold the room count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			room_count_q <= CFG_W'(64);
		end else if (cfg_valid && cfg_ready) begin
			room_count_q <= room_count;
		end
	end

	// Clamp the room count into 1..MAX_ROOMS
	always_comb begin
		if (room_count_q == '0) begin
			rooms_used = NUM_W'(1);
		end else if (32'(room_count_q) > 32'(MAX_ROOMS)) begin
			rooms_used = NUM_W'(MAX_ROOMS);
		end else begin
			rooms_used = NUM_W'(room_count_q);
		end
	end

	assign in_range = (32'(idx_q) < 32'(rooms_used));

	// Pick the room and build its updated record
	always_comb begin
		sel_room  = found_q ? found_room_q : min_room_q;
		sel_cnt   = found_q ? found_cnt_q : min_cnt_q;
		base_time = found_q ? TIME_W'(start_q) : min_free_q;
		sum_time  = {1'b0, base_time} + (TIME_W+1)'(len_q);
		fin_time  = sum_time[TIME_W] ? '1 : sum_time[TIME_W-1:0];
		new_cnt   = (sel_cnt == '1) ? sel_cnt : sel_cnt + CNT_W'(1);
		take_best = (new_cnt > best_cnt_q) ||
		            ((new_cnt == best_cnt_q) && (sel_room < best_room_q));
		wr_rec.free_time = fin_time;
		wr_rec.use_count = new_cnt;
	end

	// Build the ring of room cells; each takes its upper neighbor's record
	for (genvar g = 0; g < MAX_ROOMS; g++) begin : g_cell
		cell_ctl_t ctl;
		assign ctl.shift = (state_q == ST_SCAN);
		assign ctl.write = (state_q == ST_DONE) && (sel_room == ROOM_W'(g));
		lfra_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.nxt_rec (rec[(g + 1) % MAX_ROOMS]),
			.wr_rec  (wr_rec),
			.rec     (rec[g])
		);
	end

	// Advance the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					if (accept) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					idx_q <= idx_q + ROOM_W'(1);
					if (32'(idx_q) == MAX_ROOMS - 1) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Latch the booking and track the search as rooms pass the head cell
	always_ff @(posedge clk) begin
		if (accept) begin
			start_q <= start_time;
			len_q   <= (end_time > start_time) ? end_time - start_time : '0;
			found_q <= 1'b0;
		end else if (state_q == ST_SCAN && in_range) begin
			if (!found_q && head.free_time <= TIME_W'(start_q)) begin
				found_q      <= 1'b1;
				found_room_q <= idx_q;
				found_cnt_q  <= head.use_count;
			end
			if (idx_q == '0 || head.free_time < min_free_q) begin
				min_free_q <= head.free_time;
				min_room_q <= idx_q;
				min_cnt_q  <= head.use_count;
			end
		end
	end

	// Update the busiest room and the strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_room_q <= '0;
			best_cnt_q  <= '0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= (state_q == ST_DONE);
			if (state_q == ST_DONE && take_best) begin
				best_room_q <= sel_room;
				best_cnt_q  <= new_cnt;
			end
		end
	end

	// Register the result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_DONE) begin
			res_room_q    <= OUT_ROOM_W'(sel_room);
			res_delayed_q <= !found_q;
			res_finish_q  <= fin_time;
		end
	end

	assign result_valid  = res_valid_q;
	assign assigned_room = res_room_q;
	assign was_delayed   = res_delayed_q;
	assign finish_time   = res_finish_q;
	assign busiest_room  = OUT_ROOM_W'(best_room_q);
	assign busiest_count = best_cnt_q;

endmodule

FILE: hw/rtl/lfra_cell.sv
// One room cell of the allocator's rotating row: holds free time and use count.
// Depends on lfra_pkg for the record and control types.
module lfra_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  lfra_pkg::cell_ctl_t ctl,
	input  lfra_pkg::room_rec_t nxt_rec,
	input  lfra_pkg::room_rec_t wr_rec,
	output lfra_pkg::room_rec_t rec
);
	import lfra_pkg::*;

	room_rec_t rec_q;

	// Rotate one place along the row, or take the updated record
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q <= '0;
		end else if (ctl.shift) begin
			rec_q <= nxt_rec;
		end else if (ctl.write) begin
			rec_q <= wr_rec;
		end
	end

	assign rec = rec_q;

endmodule
